### sv/fault_table_with_aging_core_macros.svh
// Assertion macros for the fault table checker.
// Needs nothing else; included by the checker file.
`ifndef FAULT_TABLE_WITH_AGING_CORE_MACROS_SVH
`define FAULT_TABLE_WITH_AGING_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define FTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fault table check failed");

// next-cycle implication, disabled during reset
`define FTA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fault table check failed");

`endif

### sv/fta_pkg.sv
// Shared types and constants of the fault table with aging.
// No dependencies; imported by every RTL module.
package fta_pkg;

    localparam int TABLE_DEPTH = 8;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int RANK_W = 4;
    localparam int CODE_W = 5;
    localparam int AGE_W  = 8;

    localparam logic [AGE_W-1:0] CLEAR_RESET = AGE_W'(10);

    localparam logic REQ_REPORT = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [CODE_W-1:0] code;
        logic [AGE_W-1:0]  age;
    } t_entry;

    typedef struct packed {
        logic             rank_hit;
        logic             keep;
        logic [AGE_W-1:0] next_age;
    } t_scan_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DUP,
        S_SHIFT,
        S_APPEND,
        S_AGE,
        S_LIST
    } t_state;

endpackage

### sv/fta_slot_mem.sv
// Slot storage: one write port, one registered read port.
// Depends on fta_pkg.
module fta_slot_mem (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [fta_pkg::IDX_W-1:0] i_waddr,
    input  fta_pkg::t_entry     i_wdata,
    input  logic [fta_pkg::IDX_W-1:0] i_raddr,
    output fta_pkg::t_entry     o_rdata
);
    import fta_pkg::*;

    t_entry r_mem [0:TABLE_DEPTH-1];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/fta_scan_unit.sv
// Shared scan datapath: rank compare, age increment and expiry compare.
// Depends on fta_pkg.
module fta_scan_unit (
    input  fta_pkg::t_entry           i_entry,
    input  logic [fta_pkg::RANK_W-1:0] i_req_rank,
    input  logic [fta_pkg::AGE_W-1:0]  i_clear,
    output fta_pkg::t_scan_res        o_res
);
    import fta_pkg::*;

    logic [AGE_W:0] age_inc;

    // one bit wider so a saturated age always expires
    assign age_inc        = {1'b0, i_entry.age} + (AGE_W + 1)'(1);
    assign o_res.rank_hit = (i_entry.rank == i_req_rank);
    assign o_res.keep     = (age_inc <= {1'b0, i_clear});
    assign o_res.next_age = age_inc[AGE_W-1:0];

endmodule

### sv/fault_table_with_aging_core.sv
// Fault table with aging. A report scans for a duplicate rank and leaves the table unchanged
// on a hit; else, on a full table, it shifts every entry down to drop the oldest, then appends.
// A tick ages and compacts the entries in place, drops the expired ones and then lists the
// survivors, if any; the last entry comes in the final busy cycle. All passes share the single
// read port of the slot memory; next request taken once busy falls.
// Synchronous active-low reset empties the table, clear_count 10; no stall on results.
module fault_table_with_aging_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic                        i_req_type,
    input  logic [fta_pkg::RANK_W-1:0]  i_rank,
    input  logic [fta_pkg::CODE_W-1:0]  i_code_id,
    input  logic                        i_cfg_we,
    input  logic [fta_pkg::AGE_W-1:0]   i_cfg_wdata,
    output logic                        o_res_valid,
    output logic [fta_pkg::AGE_W-1:0]   o_age,
    output logic [fta_pkg::RANK_W-1:0]  o_rank_res,
    output logic [fta_pkg::CODE_W-1:0]  o_code_id_res,
    output logic                        o_last
);
    import fta_pkg::*;

    // sequencer state
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_rd_cnt, n_rd_cnt;   // next slot to read
    logic [CNT_W-1:0]   r_rd_pos, n_rd_pos;   // slot held in read data
    logic               r_rv, n_rv;           // read data valid
    logic [CNT_W-1:0]   r_kept, n_kept;       // survivors so far on a tick
    logic [CNT_W-1:0]   r_occ, n_occ;         // table occupancy
    logic [AGE_W-1:0]   r_clear;              // clear_count register

    // latched request payload
    logic [RANK_W-1:0]  r_req_rank, n_req_rank;
    logic [CODE_W-1:0]  r_req_code, n_req_code;

    // output register
    logic               r_out_vld, n_out_vld;
    logic [AGE_W-1:0]   r_out_age, n_out_age;
    logic [RANK_W-1:0]  r_out_rank, n_out_rank;
    logic [CODE_W-1:0]  r_out_code, n_out_code;
    logic               r_out_last, n_out_last;

    // memory and scan unit hookup
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    t_entry             mem_wdata;
    t_entry             rd_q;
    t_scan_res          scan;

    logic               busy;
    logic               start_acc;
    logic               scan_active;
    logic               issue;
    logic               pass_done;
    logic [CNT_W-1:0]   shift_dst;
    logic [CNT_W-1:0]   occ_m1;

    fta_slot_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_rd_cnt[IDX_W-1:0]),
        .o_rdata (rd_q)
    );

    fta_scan_unit u_scan (
        .i_entry    (rd_q),
        .i_req_rank (r_req_rank),
        .i_clear    (r_clear),
        .o_res      (scan)
    );

    // busy also covers a result still sitting in the output register
    assign busy      = (r_state != S_IDLE) || r_out_vld;
    assign start_acc = i_start && !busy;

    assign scan_active = (r_state == S_DUP) || (r_state == S_SHIFT) ||
                         (r_state == S_AGE) || (r_state == S_LIST);
    assign issue       = scan_active && (r_rd_cnt < r_occ);
    // all reads issued and the last one consumed
    assign pass_done   = (r_rd_cnt >= r_occ) && !r_rv;
    assign shift_dst   = r_rd_pos - CNT_W'(1);
    assign occ_m1      = r_occ - CNT_W'(1);

    always_comb begin
        n_state    = r_state;
        n_rd_cnt   = r_rd_cnt;
        n_rd_pos   = r_rd_pos;
        n_rv       = 1'b0;
        n_kept     = r_kept;
        n_occ      = r_occ;
        n_req_rank = r_req_rank;
        n_req_code = r_req_code;
        n_out_vld  = 1'b0;
        n_out_age  = r_out_age;
        n_out_rank = r_out_rank;
        n_out_code = r_out_code;
        n_out_last = r_out_last;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;

        // streaming read: one slot a cycle during any scan pass
        if (issue) begin
            n_rd_cnt = r_rd_cnt + CNT_W'(1);
            n_rd_pos = r_rd_cnt;
            n_rv     = 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (start_acc) begin
                    n_req_rank = i_rank;
                    n_req_code = i_code_id;
                    n_rd_cnt   = '0;
                    if (i_req_type == REQ_TICK) begin
                        n_kept  = '0;
                        n_state = S_AGE;
                    end else begin
                        n_state = S_DUP;
                    end
                end
            end

            S_DUP: begin
                priority if (r_rv && scan.rank_hit) begin
                    // duplicate rank: table unchanged
                    n_rv    = 1'b0;
                    n_state = S_IDLE;
                end else if (pass_done) begin
                    if (r_occ == CNT_W'(TABLE_DEPTH)) begin
                        n_rd_cnt = CNT_W'(1);
                        n_state  = S_SHIFT;
                    end else begin
                        n_state = S_APPEND;
                    end
                end
            end

            S_SHIFT: begin
                // move slot i down to i-1, dropping the oldest
                if (r_rv) begin
                    mem_we    = 1'b1;
                    mem_waddr = shift_dst[IDX_W-1:0];
                    mem_wdata = rd_q;
                end
                if (pass_done) begin
                    n_occ   = occ_m1;
                    n_state = S_APPEND;
                end
            end

            S_APPEND: begin
                mem_we         = 1'b1;
                mem_waddr      = r_occ[IDX_W-1:0];
                mem_wdata.rank = r_req_rank;
                mem_wdata.code = r_req_code;
                mem_wdata.age  = '0;
                n_occ          = r_occ + CNT_W'(1);
                n_state        = S_IDLE;
            end

            S_AGE: begin
                // age and compact in place; writes never pass the read pointer
                if (r_rv && scan.keep) begin
                    mem_we         = 1'b1;
                    mem_waddr      = r_kept[IDX_W-1:0];
                    mem_wdata.rank = rd_q.rank;
                    mem_wdata.code = rd_q.code;
                    mem_wdata.age  = scan.next_age;
                    n_kept         = r_kept + CNT_W'(1);
                end
                if (pass_done) begin
                    n_occ    = r_kept;
                    n_rd_cnt = '0;
                    if (r_kept == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_LIST;
                    end
                end
            end

            S_LIST: begin
                if (r_rv) begin
                    n_out_vld  = 1'b1;
                    n_out_age  = rd_q.age;
                    n_out_rank = rd_q.rank;
                    n_out_code = rd_q.code;
                    n_out_last = (r_rd_pos == occ_m1);
                end
                if (pass_done) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_cnt  <= '0;
            r_rd_pos  <= '0;
            r_rv      <= 1'b0;
            r_kept    <= '0;
            r_occ     <= '0;
            r_clear   <= CLEAR_RESET;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_cnt  <= n_rd_cnt;
            r_rd_pos  <= n_rd_pos;
            r_rv      <= n_rv;
            r_kept    <= n_kept;
            r_occ     <= n_occ;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_clear <= i_cfg_wdata;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_req_rank <= n_req_rank;
        r_req_code <= n_req_code;
        r_out_age  <= n_out_age;
        r_out_rank <= n_out_rank;
        r_out_code <= n_out_code;
        r_out_last <= n_out_last;
    end

    assign o_busy        = busy;
    assign o_res_valid   = r_out_vld;
    assign o_age         = r_out_age;
    assign o_rank_res    = r_out_rank;
    assign o_code_id_res = r_out_code;
    assign o_last        = r_out_last;

endmodule

### sv/fta_checker.sv
// Port-level checker for the fault table core, bound to the top level.
// Depends on fault_table_with_aging_core_macros.svh.
`include "fault_table_with_aging_core_macros.svh"

module fta_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_res_valid,
    input logic       o_last,
    input logic [7:0] o_age
);

    // results only while a request is in hand
    `FTA_ASSERT_IMP(a_res_in_busy, i_clk, i_rst_n, o_res_valid, o_busy)
    // an accepted request is always followed by busy being high
    `FTA_ASSERT_NXT(a_acc_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    // listing streams without gaps until the last entry
    `FTA_ASSERT_NXT(a_list_stream, i_clk, i_rst_n, o_res_valid && !o_last, o_res_valid)
    // nothing follows the last entry; a listed entry has aged at least once
    `FTA_ASSERT_NXT(a_last_ends, i_clk, i_rst_n, o_res_valid && o_last, !o_res_valid)
    `FTA_ASSERT_IMP(a_age_nonzero, i_clk, i_rst_n, o_res_valid, o_age != 8'd0)

endmodule

bind fault_table_with_aging_core fta_checker u_fta_checker (.*);
